// ===== rtl/scfp_pkg.sv =====
package scfp_pkg;

    localparam int HEAD_BYTES        = 6;
    localparam int FRAME_OVERHEAD    = 7;
    localparam int MIN_POINT_PAYLOAD = 5;
    localparam int POINT_HEAD        = 4;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = 2;
    localparam int FRAME_CNT_W       = 17;

    localparam logic [1:0] CFG_HEADER_WORD      = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_COMMAND = 2'd2;

    localparam logic [7:0] FRAMES_MAX = 8'hFF;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_HEADER       = 4'd1,
        ST_VERSION      = 4'd2,
        ST_COMMAND      = 4'd3,
        ST_CHECKSUM     = 4'd4,
        ST_POINT_SHORT  = 4'd5,
        ST_POINT_LENGTH = 4'd6,
        ST_INCOMPLETE   = 4'd7,
        ST_BUFFER_SHORT = 4'd8
    } status_t;

    typedef enum logic {
        KIND_FRAME   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [15:0]            payload_length;
        logic [15:0]            payload_position;
        logic [7:0]             running_sum;
        logic [7:0]             captured_id;
        logic [7:0]             captured_type;
        logic [15:0]            captured_length;
        logic [31:0]            captured_value;
        logic [FRAME_CNT_W-1:0] bytes_in_frame;
        status_t                pending_status;
    } frame_t;

    typedef struct packed {
        kind_t       result_kind;
        status_t     status;
        logic [7:0]  frame_index;
        logic        has_point;
        logic [7:0]  point_id;
        logic [7:0]  point_type;
        logic [15:0] point_length;
        logic [31:0] point_value;
        logic        last;
    } result_t;

endpackage

// ===== rtl/scfp_byte_if.sv =====
interface scfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_start;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_start, output buffer_end,
                    input ready);
    modport sink (input valid, input rx_byte, input buffer_start, input buffer_end,
                  output ready);
endinterface

// ===== rtl/scfp_result_if.sv =====
interface scfp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [3:0]  status;
    logic [7:0]  frame_index;
    logic        has_point;
    logic [7:0]  point_id;
    logic [7:0]  point_type;
    logic [15:0] point_length;
    logic [31:0] point_value;
    logic        last;

    modport source (output valid, output result_kind, output status, output frame_index,
                    output has_point, output point_id, output point_type,
                    output point_length, output point_value, output last, input ready);
    modport sink (input valid, input result_kind, input status, input frame_index,
                  input has_point, input point_id, input point_type,
                  input point_length, input point_value, input last, output ready);
endinterface

// ===== rtl/sum_checksum_frame_parser.sv =====
// Frame parser for a received byte stream of header/length frames with an
// 8-bit sum checksum.
// in_ch : one byte per request, flagged buffer_start / buffer_end.
// out_ch: frame reports (after each checksum byte or on the first error)
//         and one summary per buffer_end; a byte causes at most two results,
//         the last one flagged with last.
// cfg_*  : write-only register port (header word, version, command).
// Throughput: one byte per cycle while in_ch.ready is high. The parse state
// updates in the cycle a byte is taken; its results are written into a
// 4-entry output queue whose head drives out_ch. in_ch.ready is high while
// the queue has room for two results, so it drops only when the receiver
// stalls or when bytes that yield two results arrive faster than they drain.
// Reset: parse state cleared, queue emptied, registers back to 0x55AA, 3, 7.
// A byte that arrives without buffer_start after reset or after a buffer
// end opens a new buffer. Bytes past BUFFER_BYTES in a buffer are not parsed.
module sum_checksum_frame_parser #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    scfp_byte_if.sink   in_ch,
    scfp_result_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import scfp_pkg::*;

    localparam int BCW = $clog2(BUFFER_BYTES + 1);
    localparam logic [BCW-1:0] BUF_LIMIT = BCW'(BUFFER_BYTES);

    logic [15:0] header_word_reg;
    logic [7:0]  expected_version_reg;
    logic [7:0]  expected_command_reg;

    frame_t         frame_reg, frame_next;
    logic [7:0]     frames_reg, frames_next;
    logic [BCW-1:0] bib_reg, bib_next;
    logic           halted_reg, halted_next;
    status_t        fault_reg, fault_next;

    result_t r0, r1;
    logic    r0_valid, r1_valid;

    result_t              res_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 in_acc, out_acc;

    assign in_ch.ready = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_ch.valid && out_ch.ready;

    always_comb
    begin
        logic [7:0]  b;
        status_t     bad;
        status_t     st;
        logic [2:0]  vlen;
        logic [15:0] q;
        b           = in_ch.rx_byte;
        bad         = ST_OK;
        st          = ST_OK;
        vlen        = '0;
        q           = '0;
        frame_next  = frame_reg;
        frames_next = frames_reg;
        bib_next    = bib_reg;
        halted_next = halted_reg;
        fault_next  = fault_reg;
        r0          = '0;
        r1          = '0;
        r0_valid    = 1'b0;
        r1_valid    = 1'b0;

        if (in_ch.buffer_start)
        begin
            frame_next  = '0;
            frames_next = '0;
            bib_next    = '0;
            halted_next = 1'b0;
            fault_next  = ST_OK;
        end

        if (bib_next < BUF_LIMIT)
        begin
            bib_next = bib_next + 1'b1;
            if (!halted_next)
            begin
                if (frame_next.bytes_in_frame < FRAME_CNT_W'(HEAD_BYTES))
                begin
                    case (frame_next.bytes_in_frame[2:0])
                        3'd0: if (b != header_word_reg[15:8]) bad = ST_HEADER;
                        3'd1: if (b != header_word_reg[7:0]) bad = ST_HEADER;
                        3'd2: if (b != expected_version_reg) bad = ST_VERSION;
                        3'd3: if (b != expected_command_reg) bad = ST_COMMAND;
                        3'd4: frame_next.payload_length = {b, 8'h00};
                        3'd5: frame_next.payload_length = {frame_next.payload_length[15:8], b};
                        default: bad = ST_OK;
                    endcase
                    if (bad != ST_OK && frame_next.pending_status == ST_OK)
                        frame_next.pending_status = bad;
                    frame_next.running_sum    = frame_next.running_sum + b;
                    frame_next.bytes_in_frame = frame_next.bytes_in_frame + 1'b1;
                end
                else if (frame_next.bytes_in_frame == FRAME_CNT_W'(HEAD_BYTES) &&
                         frame_next.pending_status != ST_OK)
                begin
                    st = frame_next.pending_status;
                end
                else if (frame_next.payload_position < frame_next.payload_length)
                begin
                    q    = frame_next.payload_position;
                    vlen = (frame_next.captured_length < 16'(POINT_HEAD)) ?
                           frame_next.captured_length[2:0] : 3'(POINT_HEAD);
                    case (q)
                        16'd0: frame_next.captured_id = b;
                        16'd1: frame_next.captured_type = b;
                        16'd2: frame_next.captured_length = {b, 8'h00};
                        16'd3: frame_next.captured_length =
                               {frame_next.captured_length[15:8], b};
                        default:
                            if ((q - 16'(POINT_HEAD)) < {13'd0, vlen})
                                frame_next.captured_value = {frame_next.captured_value[23:0], b};
                    endcase
                    frame_next.payload_position = q + 1'b1;
                    frame_next.running_sum      = frame_next.running_sum + b;
                    frame_next.bytes_in_frame   = frame_next.bytes_in_frame + 1'b1;
                end
                else
                begin
                    if (b != frame_next.running_sum)
                        st = ST_CHECKSUM;
                    else if (frame_next.payload_length != '0 &&
                             frame_next.payload_length < 16'(MIN_POINT_PAYLOAD))
                        st = ST_POINT_SHORT;
                    else if (frame_next.payload_length != '0 &&
                             {1'b0, frame_next.payload_length} <
                             17'(POINT_HEAD) + {1'b0, frame_next.captured_length})
                        st = ST_POINT_LENGTH;
                    if (st == ST_OK)
                    begin
                        r0_valid       = 1'b1;
                        r0.result_kind = KIND_FRAME;
                        r0.status      = ST_OK;
                        r0.frame_index = frames_next;
                        if (frame_next.payload_length != '0)
                        begin
                            r0.has_point    = 1'b1;
                            r0.point_id     = frame_next.captured_id;
                            r0.point_type   = frame_next.captured_type;
                            r0.point_length = frame_next.captured_length;
                            r0.point_value  = frame_next.captured_value;
                        end
                        if (frames_next != FRAMES_MAX)
                            frames_next = frames_next + 1'b1;
                        frame_next = '0;
                    end
                end
                if (st != ST_OK)
                begin
                    fault_next     = st;
                    halted_next    = 1'b1;
                    r0_valid       = 1'b1;
                    r0.result_kind = KIND_FRAME;
                    r0.status      = st;
                    r0.frame_index = frames_next;
                end
            end
        end

        if (in_ch.buffer_end)
        begin
            r1_valid       = 1'b1;
            r1.result_kind = KIND_SUMMARY;
            r1.frame_index = frames_next;
            r1.last        = 1'b1;
            if (halted_next)
                r1.status = fault_next;
            else if (bib_next < BCW'(FRAME_OVERHEAD))
                r1.status = ST_BUFFER_SHORT;
            else if (frame_next.bytes_in_frame >= FRAME_CNT_W'(FRAME_OVERHEAD))
                r1.status = ST_INCOMPLETE;
            else
                r1.status = ST_OK;
            frame_next  = '0;
            frames_next = '0;
            bib_next    = '0;
            halted_next = 1'b0;
            fault_next  = ST_OK;
        end

        r0.last = !r1_valid;
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_acc)
            count_next = count_next + {{FIFO_AW{1'b0}}, r0_valid} + {{FIFO_AW{1'b0}}, r1_valid};
        if (out_acc)
            count_next = count_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_word_reg      <= 16'h55AA;
            expected_version_reg <= 8'd3;
            expected_command_reg <= 8'd7;
            frame_reg            <= '0;
            frames_reg           <= '0;
            bib_reg              <= '0;
            halted_reg           <= 1'b0;
            fault_reg            <= ST_OK;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
            count_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER_WORD:      header_word_reg      <= cfg_data;
                    CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data[7:0];
                    CFG_EXPECTED_COMMAND: expected_command_reg <= cfg_data[7:0];
                    default:              header_word_reg      <= header_word_reg;
                endcase
            end
            if (in_acc)
            begin
                frame_reg  <= frame_next;
                frames_reg <= frames_next;
                bib_reg    <= bib_next;
                halted_reg <= halted_next;
                fault_reg  <= fault_next;
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(r0_valid) + FIFO_AW'(r1_valid);
            end
            if (out_acc)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (r0_valid)
                res_mem_reg[wr_ptr_reg] <= r0;
            if (r1_valid)
                res_mem_reg[wr_ptr_reg + FIFO_AW'(r0_valid)] <= r1;
        end
    end

    result_t head;
    assign head = res_mem_reg[rd_ptr_reg];

    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.result_kind  = head.result_kind;
    assign out_ch.status       = head.status;
    assign out_ch.frame_index  = head.frame_index;
    assign out_ch.has_point    = head.has_point;
    assign out_ch.point_id     = head.point_id;
    assign out_ch.point_type   = head.point_type;
    assign out_ch.point_length = head.point_length;
    assign out_ch.point_value  = head.point_value;
    assign out_ch.last         = head.last;

endmodule

// ===== rtl/scfp_checker.sv =====
module scfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_buffer_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_result_kind,
    input logic [3:0]  out_status,
    input logic        out_has_point,
    input logic        out_last
);
    import scfp_pkg::*;

    // a request held by the receiver stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    // every buffer end yields a summary, so something is queued next cycle
    a_end_yields: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_buffer_end |=> out_valid)
        else $error("no result after buffer end");

    a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result_kind |-> !out_has_point && out_last)
        else $error("malformed summary");

    a_point_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_has_point |-> !out_result_kind && out_status == ST_OK)
        else $error("data point on a failed frame");

endmodule

bind sum_checksum_frame_parser scfp_checker u_scfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_buffer_end   (in_ch.buffer_end),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result_kind (out_ch.result_kind),
    .out_status      (out_ch.status),
    .out_has_point   (out_ch.has_point),
    .out_last        (out_ch.last)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import scfp_pkg::*;

    localparam int BUFFER_BYTES  = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 100;
    localparam int PHASES        = 5;

    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_VERSION,
        FLAW_COMMAND,
        FLAW_CHECKSUM
    } flaw_t;

    typedef enum int {
        TAIL_NONE,
        TAIL_FRAGMENT,
        TAIL_INCOMPLETE,
        TAIL_NOISE,
        TAIL_OPEN
    } tail_t;

    typedef struct {
        logic [7:0] data;
        logic       start_flag;
        logic       end_flag;
    } rx_req_t;

    class frame_report_board;
        logic [15:0] header_word;
        logic [7:0]  version;
        logic [7:0]  command;

        logic [15:0] payload_length;
        logic [15:0] payload_position;
        logic [7:0]  running_sum;
        logic [7:0]  cap_id;
        logic [7:0]  cap_type;
        logic [15:0] cap_length;
        logic [31:0] cap_value;
        logic [7:0]  frames_done;
        int unsigned buffer_bytes_seen;
        int unsigned frame_bytes_seen;
        bit          halted;
        status_t     pending_error;
        status_t     fault;

        result_t     step_reports[$];
        result_t     pending_reports[$];
        int          mismatches;

        function new();
            header_word = 16'h55AA;
            version     = 8'd3;
            command     = 8'd7;
            mismatches  = 0;
            clear_buffer();
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_HEADER_WORD:      header_word = value;
                CFG_EXPECTED_VERSION: version = value[7:0];
                CFG_EXPECTED_COMMAND: command = value[7:0];
                default: ;
            endcase
        endfunction

        function void clear_frame();
            payload_length   = '0;
            payload_position = '0;
            running_sum      = '0;
            cap_id           = '0;
            cap_type         = '0;
            cap_length       = '0;
            cap_value        = '0;
            frame_bytes_seen = 0;
            pending_error    = ST_OK;
        endfunction

        function void clear_buffer();
            clear_frame();
            frames_done       = '0;
            buffer_bytes_seen = 0;
            halted            = 1'b0;
            fault             = ST_OK;
        endfunction

        function void add_report(kind_t kind, status_t status, bit with_point);
            result_t r;
            r             = '0;
            r.result_kind = kind;
            r.status      = status;
            r.frame_index = frames_done;
            r.has_point   = with_point;
            if (with_point)
            begin
                r.point_id     = cap_id;
                r.point_type   = cap_type;
                r.point_length = cap_length;
                r.point_value  = cap_value;
            end
            step_reports.push_back(r);
        endfunction

        function void fail(status_t status);
            fault  = status;
            halted = 1'b1;
            add_report(KIND_FRAME, status, 1'b0);
        endfunction

        function void parse(logic [7:0] data);
            status_t     bad;
            int unsigned q;
            int unsigned value_bytes;
            bad = ST_OK;
            if (frame_bytes_seen < HEAD_BYTES)
            begin
                case (frame_bytes_seen)
                    0: if (data != header_word[15:8]) bad = ST_HEADER;
                    1: if (data != header_word[7:0]) bad = ST_HEADER;
                    2: if (data != version) bad = ST_VERSION;
                    3: if (data != command) bad = ST_COMMAND;
                    4: payload_length[15:8] = data;
                    default: payload_length[7:0] = data;
                endcase
                if (bad != ST_OK && pending_error == ST_OK)
                    pending_error = bad;
                running_sum = running_sum + data;
                frame_bytes_seen++;
                return;
            end
            // header errors surface on the seventh byte of the frame
            if (frame_bytes_seen == HEAD_BYTES && pending_error != ST_OK)
            begin
                fail(pending_error);
                return;
            end
            if (payload_position < payload_length)
            begin
                q = payload_position;
                value_bytes = cap_length < POINT_HEAD ? cap_length : POINT_HEAD;
                if (q == 0)
                    cap_id = data;
                else if (q == 1)
                    cap_type = data;
                else if (q == 2)
                    cap_length = {data, 8'h00};
                else if (q == 3)
                    cap_length[7:0] = data;
                else if (q - POINT_HEAD < value_bytes)
                    cap_value = {cap_value[23:0], data};
                payload_position++;
                running_sum = running_sum + data;
                frame_bytes_seen++;
                return;
            end
            if (data != running_sum)
                fail(ST_CHECKSUM);
            else if (payload_length != 0 && payload_length < MIN_POINT_PAYLOAD)
                fail(ST_POINT_SHORT);
            else if (payload_length != 0 && payload_length < POINT_HEAD + cap_length)
                fail(ST_POINT_LENGTH);
            else
            begin
                add_report(KIND_FRAME, ST_OK, payload_length != 0);
                if (frames_done != FRAMES_MAX)
                    frames_done++;
                clear_frame();
            end
        endfunction

        function void note_byte(logic [7:0] data, logic start_flag, logic end_flag);
            status_t summary;
            step_reports.delete();
            if (start_flag)
                clear_buffer();
            if (buffer_bytes_seen < BUFFER_BYTES)
            begin
                buffer_bytes_seen++;
                if (!halted)
                    parse(data);
            end
            if (end_flag)
            begin
                if (halted)
                    summary = fault;
                else if (buffer_bytes_seen < FRAME_OVERHEAD)
                    summary = ST_BUFFER_SHORT;
                else if (frame_bytes_seen >= FRAME_OVERHEAD)
                    summary = ST_INCOMPLETE;
                else
                    summary = ST_OK;
                add_report(KIND_SUMMARY, summary, 1'b0);
                clear_buffer();
            end
            if (step_reports.size() != 0)
                step_reports[step_reports.size() - 1].last = 1'b1;
            foreach (step_reports[i])
                pending_reports.push_back(step_reports[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report: kind %0d status %0d index %0d",
                       got.result_kind, got.status, got.frame_index);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("status", want.status, got.status);
            compare_field("frame_index", want.frame_index, got.frame_index);
            compare_field("has_point", want.has_point, got.has_point);
            compare_field("point_id", want.point_id, got.point_id);
            compare_field("point_type", want.point_type, got.point_type);
            compare_field("point_length", want.point_length, got.point_length);
            compare_field("point_value", want.point_value, got.point_value);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    scfp_byte_if   in_ch();
    scfp_result_if out_ch();

    sum_checksum_frame_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_report_board reports;
    rx_req_t           byte_plan[$];
    logic [7:0]        frame_buf[$];
    bit                idle_on;
    bit                stall_on;
    int                sent_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                reports.note_byte(in_ch.rx_byte, in_ch.buffer_start, in_ch.buffer_end);
            if (out_ch.valid && out_ch.ready)
            begin
                got.result_kind  = kind_t'(out_ch.result_kind);
                got.status       = status_t'(out_ch.status);
                got.frame_index  = out_ch.frame_index;
                got.has_point    = out_ch.has_point;
                got.point_id     = out_ch.point_id;
                got.point_type   = out_ch.point_type;
                got.point_length = out_ch.point_length;
                got.point_value  = out_ch.point_value;
                got.last         = out_ch.last;
                reports.check_report(got);
            end
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic void plan_byte(logic [7:0] data);
        byte_plan.push_back('{data, 1'b0, 1'b0});
    endfunction

    function automatic void seal_frame();
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < frame_buf.size() - 1; i++)
            sum = sum + frame_buf[i];
        frame_buf[frame_buf.size() - 1] = sum;
    endfunction

    function automatic void build_frame(flaw_t flaw, int unsigned plen);
        logic [15:0] len16;
        logic [15:0] point_len;
        len16 = 16'(plen);
        frame_buf.delete();
        frame_buf.push_back(reports.header_word[15:8]);
        frame_buf.push_back(reports.header_word[7:0]);
        frame_buf.push_back(reports.version);
        frame_buf.push_back(reports.command);
        frame_buf.push_back(len16[15:8]);
        frame_buf.push_back(len16[7:0]);
        if (plen < POINT_HEAD || $urandom_range(0, 7) == 0)
            point_len = 16'($urandom_range(0, 65535));
        else
            point_len = 16'($urandom_range(0, plen - POINT_HEAD));
        for (int i = 0; i < plen; i++)
        begin
            if (i == 2)
                frame_buf.push_back(point_len[15:8]);
            else if (i == 3)
                frame_buf.push_back(point_len[7:0]);
            else
                frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        case (flaw)
            FLAW_HEADER:  frame_buf[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FLAW_VERSION: frame_buf[2] ^= 8'($urandom_range(1, 255));
            FLAW_COMMAND: frame_buf[3] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        frame_buf.push_back(8'h00);
        seal_frame();
        if (flaw == FLAW_CHECKSUM)
            frame_buf[frame_buf.size() - 1] += 8'($urandom_range(1, 255));
    endfunction

    function automatic flaw_t pick_flaw();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return FLAW_NONE;
        else if (r == 14)
            return FLAW_HEADER;
        else if (r == 15)
            return FLAW_VERSION;
        else if (r == 16)
            return FLAW_COMMAND;
        return FLAW_CHECKSUM;
    endfunction

    function automatic int unsigned pick_payload_length();
        int r;
        r = $urandom_range(0, 39);
        if (r < 8)
            return 0;
        else if (r < 12)
            return $urandom_range(1, POINT_HEAD);
        else if (r < 36)
            return $urandom_range(MIN_POINT_PAYLOAD, 16);
        else if (r < 39)
            return $urandom_range(17, 80);
        return $urandom_range(200, 400);
    endfunction

    function automatic void plan_buffer(bit with_start);
        int unsigned first;
        int          r;
        tail_t       tail;
        logic [15:0] len16;
        first = byte_plan.size();
        repeat ($urandom_range(0, 4))
        begin
            build_frame(pick_flaw(), pick_payload_length());
            foreach (frame_buf[i])
                plan_byte(frame_buf[i]);
        end
        r = $urandom_range(0, 9);
        if (r < 5)
            tail = TAIL_NONE;
        else if (r == 5)
            tail = TAIL_FRAGMENT;
        else if (r == 6)
            tail = TAIL_INCOMPLETE;
        else if (r < 9)
            tail = TAIL_NOISE;
        else
            tail = TAIL_OPEN;
        case (tail)
            TAIL_FRAGMENT:
            begin
                build_frame(pick_flaw(), 0);
                for (int i = 0; i < $urandom_range(1, HEAD_BYTES); i++)
                    plan_byte(frame_buf[i]);
            end
            TAIL_INCOMPLETE:
            begin
                build_frame(pick_flaw(), 0);
                len16 = 16'($urandom_range(40, 65535));
                frame_buf[4] = len16[15:8];
                frame_buf[5] = len16[7:0];
                for (int i = 0; i < HEAD_BYTES; i++)
                    plan_byte(frame_buf[i]);
                repeat ($urandom_range(1, 33)) plan_byte(8'($urandom_range(0, 255)));
            end
            TAIL_NOISE:
                repeat ($urandom_range(1, 10)) plan_byte(8'($urandom_range(0, 255)));
            default: ;
        endcase
        if (byte_plan.size() == first)
            plan_byte(8'($urandom_range(0, 255)));
        byte_plan[first].start_flag = with_start;
        if (tail != TAIL_OPEN)
            byte_plan[byte_plan.size() - 1].end_flag = 1'b1;
    endfunction

    // well-formed frames running past the buffer limit; the end flag lands beyond it
    function automatic void plan_long_buffer();
        int unsigned first;
        first = byte_plan.size();
        while (byte_plan.size() - first < BUFFER_BYTES + 80)
        begin
            build_frame(FLAW_NONE, $urandom_range(MIN_POINT_PAYLOAD, 16));
            foreach (frame_buf[i])
                plan_byte(frame_buf[i]);
        end
        byte_plan[first].start_flag = 1'b1;
        byte_plan[byte_plan.size() - 1].end_flag = 1'b1;
    endfunction

    task automatic send_request(rx_req_t req);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.rx_byte      <= req.data;
        in_ch.buffer_start <= req.start_flag;
        in_ch.buffer_end   <= req.end_flag;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_plan();
        foreach (byte_plan[i])
            send_request(byte_plan[i]);
        byte_plan.delete();
    endtask

    task automatic wait_for_reports();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports.pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        reports.set_register(index, value);
    endtask

    initial
    begin
        int phase_start;
        int buffers;
        reports = new();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_HEADER_WORD;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.rx_byte      <= '0;
        in_ch.buffer_start <= 1'b0;
        in_ch.buffer_end   <= 1'b0;
        idle_on    = 1'b1;
        stall_on   = 1'b1;
        sent_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // lone byte right after reset, no start flag
        byte_plan.push_back('{8'h00, 1'b0, 1'b1});
        // bad command reported on the seventh byte, which also ends the buffer
        build_frame(FLAW_COMMAND, 0);
        foreach (frame_buf[i])
            plan_byte(frame_buf[i]);
        byte_plan[1].start_flag = 1'b1;
        byte_plan[7].end_flag   = 1'b1;
        // point with one value byte; checksum byte closes the buffer
        build_frame(FLAW_NONE, MIN_POINT_PAYLOAD);
        frame_buf[6] = 8'hFF;
        frame_buf[7] = 8'h00;
        frame_buf[8] = 8'h00;
        frame_buf[9] = 8'h01;
        seal_frame();
        foreach (frame_buf[i])
            plan_byte(frame_buf[i]);
        byte_plan[8].start_flag = 1'b1;
        byte_plan[byte_plan.size() - 1].end_flag = 1'b1;
        // header error pending when the buffer ends early
        build_frame(FLAW_HEADER, 0);
        for (int i = 0; i < 3; i++)
            plan_byte(frame_buf[i]);
        byte_plan[byte_plan.size() - 3].start_flag = 1'b1;
        byte_plan[byte_plan.size() - 1].end_flag   = 1'b1;
        send_plan();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_reports();
            case (phase)
                0:
                begin
                    write_register(CFG_HEADER_WORD, 16'h0000);
                    write_register(CFG_EXPECTED_VERSION, 16'h0000);
                    write_register(CFG_EXPECTED_COMMAND, 16'h00FF);
                end
                1:
                begin
                    write_register(CFG_HEADER_WORD, 16'hFFFF);
                    write_register(CFG_EXPECTED_VERSION, 16'h00FF);
                    write_register(CFG_EXPECTED_COMMAND, 16'h0000);
                end
                PHASES - 1:
                begin
                    write_register(CFG_HEADER_WORD, 16'h55AA);
                    write_register(CFG_EXPECTED_VERSION, 16'h0003);
                    write_register(CFG_EXPECTED_COMMAND, 16'h0007);
                end
                default:
                begin
                    write_register(CFG_HEADER_WORD, 16'($urandom_range(0, 65535)));
                    write_register(CFG_EXPECTED_VERSION, 16'($urandom_range(0, 65535)));
                    write_register(CFG_EXPECTED_COMMAND, 16'($urandom_range(0, 65535)));
                end
            endcase
            phase_start = sent_count;
            buffers = 0;
            if (phase == 3)
            begin
                plan_long_buffer();
                send_plan();
            end
            while (sent_count - phase_start < PHASE_BYTES)
            begin
                idle_on  = (phase != PHASES - 1) && $urandom_range(0, 3) != 0;
                stall_on = (phase != PHASES - 1) && $urandom_range(0, 3) != 0;
                plan_buffer($urandom_range(0, 3) != 0);
                send_plan();
                buffers++;
                // hold requests until the block has drained
                if (phase == 1 && buffers == 1)
                    wait_for_reports();
            end
        end
        wait_for_reports();
        if (reports.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sum_checksum_frame_parser.f =====
rtl/scfp_pkg.sv
rtl/scfp_byte_if.sv
rtl/scfp_result_if.sv
rtl/sum_checksum_frame_parser.sv
rtl/scfp_checker.sv
dv/tb.sv
